>>> rtl/core/dsvs_pkg.sv
// dsvs_pkg: shared types, constants and the saturation helper for the
// damped spring velocity step unit. No dependencies.
package dsvs_pkg;

    localparam int W          = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_LAT    = DIV_STEPS + 1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] root_x;
        logic signed [31:0] root_y;
        logic signed [31:0] root_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               stretched;
        logic               saturated;
    } result_t;

    typedef enum logic [2:0] {
        CFG_NAT_LEN = 3'd0,
        CFG_MASS    = 3'd1,
        CFG_GRAVITY = 3'd2,
        CFG_STIFF   = 3'd3,
        CFG_DRAG    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } clamp_t;

    // clamp a wide signed value to the 32 bit signed range
    function automatic clamp_t sat_s50(input logic signed [49:0] x);
        clamp_t c;
        if (x > 50'sd2147483647)
        begin
            c.ovf = 1'b1;
            c.val = 32'sh7fffffff;
        end
        else if (x < -50'sd2147483648)
        begin
            c.ovf = 1'b1;
            c.val = 32'sh80000000;
        end
        else
        begin
            c.ovf = 1'b0;
            c.val = x[31:0];
        end
        return c;
    endfunction

endpackage

>>> rtl/core/dsvs_delay.sv
// dsvs_delay: fixed-depth shift line that moves an item's side data and
// its valid bit alongside a long arithmetic unit. No package needed.
module dsvs_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DEPTH-1:0] << 1} | {{(DEPTH-1){1'b0}}, in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int k = 1; k < DEPTH; k++)
        begin
            data_reg[k] <= data_reg[k-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

>>> rtl/core/dsvs_isqrt.sv
// dsvs_isqrt: pipelined floor square root of a 64 bit value, one result
// bit per stage. Uses dsvs_pkg for the step count.
module dsvs_isqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    localparam int N = dsvs_pkg::SQRT_STEPS;

    logic [63:0] src_reg  [N];
    logic [33:0] rem_reg  [N];
    logic [31:0] root_reg [N];
    logic [63:0] src_next [N];
    logic [33:0] rem_next [N];
    logic [31:0] root_next[N];

    always_comb
    begin
        logic [63:0] src_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        for (int k = 0; k < N; k++)
        begin
            src_in  = (k == 0) ? radicand : src_reg[(k == 0) ? 0 : k-1];
            rem_in  = (k == 0) ? 34'd0    : rem_reg[(k == 0) ? 0 : k-1];
            root_in = (k == 0) ? 32'd0    : root_reg[(k == 0) ? 0 : k-1];
            // bring down the next two radicand bits
            rem_sh = {rem_in, src_in[63:62]};
            trial  = {2'b00, root_in, 2'b01};
            src_next[k] = {src_in[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next[k]  = 34'(rem_sh - trial);
                root_next[k] = {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh[33:0];
                root_next[k] = {root_in[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            src_reg[k]  <= src_next[k];
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign root = root_reg[N-1];

endmodule

>>> rtl/core/dsvs_div.sv
// dsvs_div: pipelined 64 by 31 bit unsigned divider giving a 32 bit
// quotient and an overflow flag. Uses dsvs_pkg for the step count.
module dsvs_div (
    input  logic        clk,
    input  logic [63:0] dividend,
    input  logic [30:0] divisor,
    output logic [31:0] quotient,
    output logic        overflow
);

    localparam int N = dsvs_pkg::DIV_STEPS;

    // user must hold config register divisor while items in flight; not enforced
    logic        ovf0_reg;
    logic [31:0] rem0_reg;
    logic [31:0] lq0_reg;
    logic        ovf_reg [N];
    logic [31:0] rem_reg [N];
    logic [31:0] lq_reg  [N];
    logic [31:0] rem_next[N];
    logic [31:0] lq_next [N];

    always_ff @(posedge clk)
    begin
        // quotient needs more than 32 bits when the high half reaches the divisor
        ovf0_reg <= (dividend[63:32] >= {1'b0, divisor});
        rem0_reg <= dividend[63:32];
        lq0_reg  <= dividend[31:0];
    end

    always_comb
    begin
        logic [31:0] rem_in;
        logic [31:0] lq_in;
        logic [32:0] rem_sh;
        for (int k = 0; k < N; k++)
        begin
            rem_in = (k == 0) ? rem0_reg : rem_reg[(k == 0) ? 0 : k-1];
            lq_in  = (k == 0) ? lq0_reg  : lq_reg[(k == 0) ? 0 : k-1];
            rem_sh = {rem_in, lq_in[31]};
            if (rem_sh >= {2'b00, divisor})
            begin
                rem_next[k] = 32'(rem_sh - {2'b00, divisor});
                lq_next[k]  = {lq_in[30:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_sh[31:0];
                lq_next[k]  = {lq_in[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k] <= rem_next[k];
            lq_reg[k]  <= lq_next[k];
            ovf_reg[k] <= (k == 0) ? ovf0_reg : ovf_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign quotient = lq_reg[N-1];
    assign overflow = ovf_reg[N-1];

endmodule

>>> rtl/core/damped_spring_velocity_step_unit.sv
// damped_spring_velocity_step_unit: top level, one Euler velocity step per item.
// An accepted item runs through stages 1 to 3, the square root, stages 4 and 5, the
// first divider, stages 6 and 7, the second divider and stages 8 to 11 to done.
// Throughput: one item per cycle; the 32-stage square root and the two 33-stage
// dividers per lane are fully pipelined. The receiver cannot stall, so busy
// is high only during reset. Reset clears all valid bits and loads the
// register defaults. Depends on dsvs_pkg, dsvs_delay, dsvs_isqrt, dsvs_div.
module damped_spring_velocity_step_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dsvs_pkg::item_t   item,
    output logic              done,
    output dsvs_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam logic [30:0] ONE_RESET  = 31'(64'd1 << FRAC_BITS);
    localparam logic [31:0] GRAV_RESET =
        32'(((64'd9807 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam int LATENCY = 3 + dsvs_pkg::SQRT_STEPS + 2 + dsvs_pkg::DIV_LAT + 2
                           + dsvs_pkg::DIV_LAT + 4;

    typedef struct packed {
        logic               neg;
        logic [31:0]        mag;
        logic signed [31:0] vel;
    } lane_a_t;

    typedef struct packed {
        lane_a_t [2:0] lane;
        logic          sat;
    } side_a_t;

    typedef struct packed {
        logic               neg;
        logic signed [31:0] vel;
    } lane_b_t;

    typedef struct packed {
        lane_b_t [2:0] lane;
        logic          stretched;
        logic          sat;
    } side_b_t;

    // ---------------- control and configuration ----------------
    logic               busy_reg;
    logic               cfg_ready_reg;
    logic [30:0]        nat_len_reg;
    logic [30:0]        mass_reg;
    logic signed [31:0] gravity_reg;
    logic [30:0]        stiff_reg;
    logic [16:0]        drag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            cfg_ready_reg <= 1'b0;
            nat_len_reg   <= ONE_RESET;
            mass_reg      <= ONE_RESET;
            gravity_reg   <= GRAV_RESET;
            stiff_reg     <= ONE_RESET;
            drag_reg      <= '0;
        end
        else
        begin
            busy_reg      <= 1'b0;
            cfg_ready_reg <= 1'b1;
            if (cfg_valid && cfg_ready_reg)
            begin
                case (dsvs_pkg::cfg_idx_t'(cfg_index))
                    dsvs_pkg::CFG_NAT_LEN: nat_len_reg <= cfg_data[30:0];
                    dsvs_pkg::CFG_MASS:    mass_reg    <= cfg_data[30:0];
                    dsvs_pkg::CFG_GRAVITY: gravity_reg <= cfg_data;
                    dsvs_pkg::CFG_STIFF:   stiff_reg   <= cfg_data[30:0];
                    dsvs_pkg::CFG_DRAG:    drag_reg    <= cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = cfg_ready_reg;

    logic [30:0]      nat_eff;
    logic [30:0]      mass_eff;
    dsvs_pkg::clamp_t gy_c;

    // a zero divisor counts as the smallest positive value
    assign nat_eff  = (nat_len_reg == '0) ? 31'd1 : nat_len_reg;
    assign mass_eff = (mass_reg == '0) ? 31'd1 : mass_reg;
    assign gy_c     = dsvs_pkg::sat_s50(-50'($signed(gravity_reg)));

    // ---------------- stage 1: offset and magnitude ----------------
    logic signed [31:0] pos_in [3];
    logic signed [31:0] root_in[3];
    logic signed [31:0] vel_in [3];
    side_a_t            s1_next;
    side_a_t            s1_reg;
    logic               s1_valid_reg;

    assign pos_in[0]  = item.pos_x;
    assign pos_in[1]  = item.pos_y;
    assign pos_in[2]  = item.pos_z;
    assign vel_in[0]  = item.vel_x;
    assign vel_in[1]  = item.vel_y;
    assign vel_in[2]  = item.vel_z;
    assign root_in[0] = item.root_x;
    assign root_in[1] = item.root_y;
    assign root_in[2] = item.root_z;

    always_comb
    begin
        dsvs_pkg::clamp_t c;
        logic             sat_acc;
        sat_acc = gy_c.ovf;
        for (int i = 0; i < 3; i++)
        begin
            c = dsvs_pkg::sat_s50(50'($signed(root_in[i])) - 50'($signed(pos_in[i])));
            sat_acc = sat_acc | c.ovf;
            s1_next.lane[i].neg = c.val[31];
            s1_next.lane[i].mag = c.val[31] ? 32'(~c.val + 32'sd1) : 32'(c.val);
            s1_next.lane[i].vel = vel_in[i];
        end
        s1_next.sat = sat_acc;
    end

    // ---------------- stages 2 and 3: squared length ----------------
    side_a_t     s2_reg;
    side_a_t     s3_reg;
    logic [63:0] sq_reg [3];
    logic [63:0] sumsq_reg;
    logic        s2_valid_reg;
    logic        s3_valid_reg;

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= s1_reg.lane[i].mag * s1_reg.lane[i].mag;
        end
        s2_reg    <= s1_reg;
        sumsq_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        s3_reg    <= s2_reg;
    end

    // ---------------- square root ----------------
    logic [31:0] len;
    logic        s3d_valid;
    side_a_t     s3d_side;

    dsvs_isqrt u_isqrt (
        .clk      (clk),
        .radicand (sumsq_reg),
        .root     (len)
    );

    dsvs_delay #(
        .WIDTH ($bits(side_a_t)),
        .DEPTH (dsvs_pkg::SQRT_STEPS)
    ) u_dly_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_data   (s3_reg),
        .out_valid (s3d_valid),
        .out_data  (s3d_side)
    );

    // ---------------- stages 4 and 5: extension and product ----------------
    side_a_t     s4_reg;
    logic [31:0] ext_reg;
    logic        s4_stretched_reg;
    logic        s4_valid_reg;
    side_b_t     s5_reg;
    logic [63:0] prod1_reg [3];
    logic        s5_valid_reg;

    always_ff @(posedge clk)
    begin
        s4_reg           <= s3d_side;
        s4_stretched_reg <= (len > {1'b0, nat_eff});
        ext_reg          <= len - {1'b0, nat_eff};
        for (int i = 0; i < 3; i++)
        begin
            prod1_reg[i]         <= s4_reg.lane[i].mag * ext_reg;
            s5_reg.lane[i].neg   <= s4_reg.lane[i].neg;
            s5_reg.lane[i].vel   <= s4_reg.lane[i].vel;
        end
        s5_reg.stretched <= s4_stretched_reg;
        s5_reg.sat       <= s4_reg.sat;
    end

    // ---------------- divide by natural length ----------------
    logic [31:0] q1   [3];
    logic        ovf1 [3];
    logic        s5d_valid;
    side_b_t     s5d_side;

    for (genvar g = 0; g < 3; g++)
    begin : g_div1
        dsvs_div u_div (
            .clk      (clk),
            .dividend (prod1_reg[g]),
            .divisor  (nat_eff),
            .quotient (q1[g]),
            .overflow (ovf1[g])
        );
    end

    dsvs_delay #(
        .WIDTH ($bits(side_b_t)),
        .DEPTH (dsvs_pkg::DIV_LAT)
    ) u_dly_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_data   (s5_reg),
        .out_valid (s5d_valid),
        .out_data  (s5d_side)
    );

    // ---------------- stages 6 and 7: clamp and stiffness ----------------
    side_b_t     s6_next;
    side_b_t     s6_reg;
    logic [31:0] tmag_next [3];
    logic [31:0] tmag_reg  [3];
    logic        s6_valid_reg;
    side_b_t     s7_reg;
    logic [62:0] p2        [3];
    logic [63:0] prod2_reg [3];
    logic        s7_valid_reg;

    always_comb
    begin
        logic [31:0] lim;
        logic        flag;
        logic        sat_acc;
        s6_next = s5d_side;
        sat_acc = s5d_side.sat;
        for (int i = 0; i < 3; i++)
        begin
            lim  = s5d_side.lane[i].neg ? 32'h80000000 : 32'h7fffffff;
            flag = ovf1[i] || (q1[i] > lim);
            tmag_next[i] = flag ? lim : q1[i];
            sat_acc = sat_acc | (s5d_side.stretched & flag);
        end
        s6_next.sat = sat_acc;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p2[i] = tmag_reg[i] * stiff_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_reg <= s6_next;
        s7_reg <= s6_reg;
        for (int i = 0; i < 3; i++)
        begin
            tmag_reg[i]  <= tmag_next[i];
            prod2_reg[i] <= {1'b0, p2[i]};
        end
    end

    // ---------------- divide by mass ----------------
    logic [31:0] q2   [3];
    logic        ovf2 [3];
    logic        s7d_valid;
    side_b_t     s7d_side;

    for (genvar g = 0; g < 3; g++)
    begin : g_div2
        dsvs_div u_div (
            .clk      (clk),
            .dividend (prod2_reg[g]),
            .divisor  (mass_eff),
            .quotient (q2[g]),
            .overflow (ovf2[g])
        );
    end

    dsvs_delay #(
        .WIDTH ($bits(side_b_t)),
        .DEPTH (dsvs_pkg::DIV_LAT)
    ) u_dly_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s7_valid_reg),
        .in_data   (s7_reg),
        .out_valid (s7d_valid),
        .out_data  (s7d_side)
    );

    // ---------------- stage 8: acceleration ----------------
    side_b_t            s8_next;
    side_b_t            s8_reg;
    logic signed [31:0] acc_next [3];
    logic signed [31:0] acc_reg  [3];
    logic               s8_valid_reg;

    always_comb
    begin
        logic [31:0]        lim;
        logic [31:0]        amag;
        logic               flag;
        logic               sat_acc;
        logic signed [49:0] a50;
        logic signed [49:0] base;
        dsvs_pkg::clamp_t   sc;
        s8_next = s7d_side;
        sat_acc = s7d_side.sat;
        for (int i = 0; i < 3; i++)
        begin
            lim  = s7d_side.lane[i].neg ? 32'h80000000 : 32'h7fffffff;
            flag = ovf2[i] || (q2[i] > lim);
            amag = flag ? lim : q2[i];
            a50  = s7d_side.lane[i].neg ? -$signed({18'd0, amag}) : $signed({18'd0, amag});
            base = (i == 1) ? 50'($signed(gy_c.val)) : 50'sd0;
            sc   = dsvs_pkg::sat_s50(base + a50);
            // without stretch only gravity acts
            acc_next[i] = s7d_side.stretched ? sc.val : base[31:0];
            sat_acc = sat_acc | (s7d_side.stretched & (flag | sc.ovf));
        end
        s8_next.sat = sat_acc;
    end

    // ---------------- stage 9: velocity sum ----------------
    side_b_t            s9_next;
    side_b_t            s9_reg;
    logic signed [31:0] v_next [3];
    logic signed [31:0] v_reg  [3];
    logic               s9_valid_reg;

    always_comb
    begin
        dsvs_pkg::clamp_t vc;
        logic             sat_acc;
        s9_next = s8_reg;
        sat_acc = s8_reg.sat;
        for (int i = 0; i < 3; i++)
        begin
            vc = dsvs_pkg::sat_s50(50'($signed(s8_reg.lane[i].vel))
                                 + 50'($signed(acc_reg[i])));
            v_next[i] = vc.val;
            s9_next.lane[i].neg = vc.val[31];
            sat_acc = sat_acc | vc.ovf;
        end
        s9_next.sat = sat_acc;
    end

    // ---------------- stage 10: drag product ----------------
    side_b_t            s10_reg;
    logic signed [31:0] v10_reg    [3];
    logic [31:0]        vmag       [3];
    logic [48:0]        prod3_reg  [3];
    logic               s10_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vmag[i] = v_reg[i][31] ? 32'(~v_reg[i] + 32'sd1) : 32'(v_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        s8_reg  <= s8_next;
        s9_reg  <= s9_next;
        s10_reg <= s9_reg;
        for (int i = 0; i < 3; i++)
        begin
            acc_reg[i]   <= acc_next[i];
            v_reg[i]     <= v_next[i];
            v10_reg[i]   <= v_reg[i];
            prod3_reg[i] <= vmag[i] * drag_reg;
        end
    end

    // ---------------- stage 11: drag removal and result ----------------
    dsvs_pkg::result_t result_next;
    dsvs_pkg::result_t result_reg;
    logic              done_reg;

    always_comb
    begin
        logic [48:0]        dm;
        logic signed [49:0] dr;
        dsvs_pkg::clamp_t   fc  [3];
        logic               sat_acc;
        sat_acc = s10_reg.sat;
        for (int i = 0; i < 3; i++)
        begin
            dm = prod3_reg[i] >> FRAC_BITS;
            dr = v10_reg[i][31] ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
            fc[i] = dsvs_pkg::sat_s50(50'($signed(v10_reg[i])) - dr);
            sat_acc = sat_acc | fc[i].ovf;
        end
        result_next.new_vel_x = fc[0].val;
        result_next.new_vel_y = fc[1].val;
        result_next.new_vel_z = fc[2].val;
        result_next.stretched = s10_reg.stretched;
        result_next.saturated = sat_acc;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // valid bits for the plain stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= start && !busy_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3d_valid;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5d_valid;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7d_valid;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            done_reg      <= s10_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every accepted item comes out after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not produce a result");

    // no result without a matching accept
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without accepted item");

    // negating the most negative gravity always clamps
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (gravity_reg == 32'sh80000000)) |-> result.saturated)
        else $error("gravity clamp not flagged");

endmodule
